// ===== rtl/pmt_sec_pkg.sv =====
// ----------------------------------------------------------------------------
// PMT section parser package
// Shared types and constants for the program map section parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pmt_sec_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HDR   = 3'd1,
    PH_PINFO = 3'd2,
    PH_ENTRY = 3'd3,
    PH_DESC  = 3'd4,
    PH_TAIL  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  // Header byte offsets counted from the table id
  localparam logic [11:0] HDR_LEN_HI   = 12'd1;
  localparam logic [11:0] HDR_LEN_LO   = 12'd2;
  localparam logic [11:0] HDR_PROG_HI  = 12'd3;
  localparam logic [11:0] HDR_PROG_LO  = 12'd4;
  localparam logic [11:0] HDR_VERSION  = 12'd5;
  localparam logic [11:0] HDR_PCR_HI   = 12'd8;
  localparam logic [11:0] HDR_PCR_LO   = 12'd9;
  localparam logic [11:0] HDR_PINFO_HI = 12'd10;
  localparam logic [11:0] HDR_LAST     = 12'd11;

  // Section length at or below this leaves no room for streams
  localparam logic [11:0] SHORT_SECTION_LEN = 12'd9;
  // Position after the header, counted from the byte after the length field
  localparam logic [11:0] BODY_START_POS    = 12'd9;
  localparam logic [2:0]  ENTRY_LAST_BYTE   = 3'd4;
  localparam logic [2:0]  DESC_INDEX_MAX    = 3'd5;
  localparam logic [2:0]  DESC_COUNT_BYTE   = 3'd1;
  localparam logic [2:0]  DESC_LANG_LAST    = 3'd4;
  localparam logic [7:0]  SUBTITLE_TAG_RST  = 8'h59;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       section_start;
  } in_item_t;

  typedef struct packed {
    kind_t        result_kind;
    logic [15:0]  program_number;
    logic [4:0]   version;
    logic [12:0]  pcr_pid;
    logic [7:0]   stream_type;
    logic [12:0]  es_pid;
    logic [11:0]  es_info_len;
    logic         subtitle_present;
    logic [23:0]  language_code;
    logic [4:0]   subtitle_entries;
    logic         section_done;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/pmt_sec_if.sv =====
// ----------------------------------------------------------------------------
// PMT section parser channels
// Byte input channel and result output channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmt_sec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       section_start;

  modport source (output valid, output data_byte, output section_start, input ready);
  modport sink   (input valid, input data_byte, input section_start, output ready);
endinterface

interface pmt_sec_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] program_number;
  logic [4:0]  version;
  logic [12:0] pcr_pid;
  logic [7:0]  stream_type;
  logic [12:0] es_pid;
  logic [11:0] es_info_len;
  logic        subtitle_present;
  logic [23:0] language_code;
  logic [4:0]  subtitle_entries;
  logic        section_done;

  modport source (
    output valid, output result_kind, output program_number, output version,
    output pcr_pid, output stream_type, output es_pid, output es_info_len,
    output subtitle_present, output language_code, output subtitle_entries,
    output section_done, input ready
  );
  modport sink (
    input valid, input result_kind, input program_number, input version,
    input pcr_pid, input stream_type, input es_pid, input es_info_len,
    input subtitle_present, input language_code, input subtitle_entries,
    input section_done, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/pmt_sec_in_stage.sv =====
// ----------------------------------------------------------------------------
// PMT section parser input register
// Captures one section byte per request and hands it to the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_sec_in_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  pmt_sec_in_if.sink               in_ch,
  input  wire logic                can_load,
  output pmt_sec_pkg::in_item_t    item,
  output logic                     step
);
  import pmt_sec_pkg::*;

  logic     valid;
  in_item_t held;

  assign step        = valid && can_load;
  assign in_ch.ready = !valid || can_load;
  assign item        = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ch.ready) begin
      valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      held.data_byte     <= in_ch.data_byte;
      held.section_start <= in_ch.section_start;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pmt_sec_parse.sv =====
// ----------------------------------------------------------------------------
// PMT section parser core
// Section state and per-byte decode of header, stream entries and descriptors.
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_sec_parse (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [7:0]          cfg_data,
  input  wire logic                step,
  input  wire pmt_sec_pkg::in_item_t item,
  output logic                     res_valid,
  output pmt_sec_pkg::result_t     res
);
  import pmt_sec_pkg::*;

  logic [7:0]  subtitle_tag;
  phase_t      phase, phase_next;
  logic [11:0] byte_position, byte_position_next;
  logic [11:0] section_len, section_len_next;
  logic [11:0] skip_remaining, skip_remaining_next;
  logic [2:0]  entry_byte_index, entry_byte_index_next;
  logic [2:0]  desc_byte_index, desc_byte_index_next;
  logic [15:0] hdr_prog, hdr_prog_next;
  logic [4:0]  hdr_version, hdr_version_next;
  logic [12:0] hdr_pcr, hdr_pcr_next;
  logic [7:0]  entry_type, entry_type_next;
  logic [12:0] entry_pid, entry_pid_next;
  logic [11:0] entry_info_len, entry_info_len_next;
  logic        entry_sub_flag, entry_sub_flag_next;
  logic [23:0] entry_language, entry_language_next;
  logic [4:0]  entry_sub_count, entry_sub_count_next;

  logic [7:0]  b;
  logic [12:0] pos_plus1, pos_plus4;

  assign b         = item.data_byte;
  assign pos_plus1 = {1'b0, byte_position} + 13'd1;
  assign pos_plus4 = {1'b0, byte_position} + 13'd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      subtitle_tag <= SUBTITLE_TAG_RST;
    end else if (cfg_write) begin
      subtitle_tag <= cfg_data;
    end
  end

  always_comb begin
    phase_next            = phase;
    byte_position_next    = byte_position;
    section_len_next      = section_len;
    skip_remaining_next   = skip_remaining;
    entry_byte_index_next = entry_byte_index;
    desc_byte_index_next  = desc_byte_index;
    hdr_prog_next         = hdr_prog;
    hdr_version_next      = hdr_version;
    hdr_pcr_next          = hdr_pcr;
    entry_type_next       = entry_type;
    entry_pid_next        = entry_pid;
    entry_info_len_next   = entry_info_len;
    entry_sub_flag_next   = entry_sub_flag;
    entry_language_next   = entry_language;
    entry_sub_count_next  = entry_sub_count;
    res_valid             = 1'b0;
    res                   = '0;

    if (step) begin
      // A new section drops whatever was in progress
      if (item.section_start) begin
        phase_next          = PH_HDR;
        byte_position_next  = '0;
        section_len_next    = '0;
        skip_remaining_next = '0;
      end

      case (phase_next)
        PH_IDLE: begin
        end
        PH_HDR: begin
          case (byte_position_next)
            HDR_LEN_HI:   section_len_next = {b[3:0], 8'h00};
            HDR_LEN_LO:   section_len_next = section_len_next | {4'h0, b};
            HDR_PROG_HI:  hdr_prog_next = {b, 8'h00};
            HDR_PROG_LO:  hdr_prog_next = hdr_prog | {8'h00, b};
            HDR_VERSION:  hdr_version_next = b[5:1];
            HDR_PCR_HI:   hdr_pcr_next = {b[4:0], 8'h00};
            HDR_PCR_LO:   hdr_pcr_next = hdr_pcr | {5'h00, b};
            HDR_PINFO_HI: skip_remaining_next = {b[3:0], 8'h00};
            HDR_LAST:     skip_remaining_next = skip_remaining | {4'h0, b};
            default: begin
            end
          endcase
          if (byte_position_next < HDR_LAST) begin
            byte_position_next = byte_position_next + 12'd1;
          end else begin
            res_valid          = 1'b1;
            res.result_kind    = KIND_HEADER;
            res.program_number = hdr_prog_next;
            res.version        = hdr_version_next;
            res.pcr_pid        = hdr_pcr_next;
            if (section_len_next <= SHORT_SECTION_LEN) begin
              res.section_done   = 1'b1;
              phase_next         = PH_IDLE;
              byte_position_next = '0;
            end else begin
              byte_position_next    = BODY_START_POS;
              entry_byte_index_next = '0;
              phase_next = (skip_remaining_next != '0) ? PH_PINFO : PH_ENTRY;
            end
          end
        end
        default: begin
          if (pos_plus1 == {1'b0, section_len}) begin
            // Last CRC byte
            res_valid          = 1'b1;
            res.result_kind    = KIND_END;
            res.section_done   = 1'b1;
            phase_next         = PH_IDLE;
            byte_position_next = '0;
          end else begin
            if (pos_plus4 >= {1'b0, section_len}) begin
              phase_next = PH_TAIL;
            end else begin
              case (phase)
                PH_PINFO: begin
                  skip_remaining_next = skip_remaining - 12'd1;
                  if (skip_remaining_next == '0) begin
                    phase_next            = PH_ENTRY;
                    entry_byte_index_next = '0;
                  end
                end
                PH_ENTRY: begin
                  case (entry_byte_index)
                    3'd0:    entry_type_next = b;
                    3'd1:    entry_pid_next = {b[4:0], 8'h00};
                    3'd2:    entry_pid_next = entry_pid | {5'h00, b};
                    3'd3:    entry_info_len_next = {b[3:0], 8'h00};
                    default: entry_info_len_next = entry_info_len | {4'h0, b};
                  endcase
                  if (entry_byte_index < ENTRY_LAST_BYTE) begin
                    entry_byte_index_next = entry_byte_index + 3'd1;
                  end else begin
                    entry_sub_flag_next  = 1'b0;
                    entry_language_next  = '0;
                    entry_sub_count_next = '0;
                    desc_byte_index_next = '0;
                    if (entry_info_len_next == '0) begin
                      res_valid             = 1'b1;
                      phase_next            = PH_ENTRY;
                      entry_byte_index_next = '0;
                    end else begin
                      skip_remaining_next = entry_info_len_next;
                      phase_next          = PH_DESC;
                    end
                  end
                end
                PH_DESC: begin
                  if (desc_byte_index == '0) begin
                    entry_sub_flag_next = (b == subtitle_tag);
                  end else if (entry_sub_flag) begin
                    if (desc_byte_index == DESC_COUNT_BYTE) begin
                      entry_sub_count_next = b[7:3];
                    end else if (desc_byte_index <= DESC_LANG_LAST) begin
                      entry_language_next = {entry_language[15:0], b};
                    end
                  end
                  if (desc_byte_index < DESC_INDEX_MAX) begin
                    desc_byte_index_next = desc_byte_index + 3'd1;
                  end
                  skip_remaining_next = skip_remaining - 12'd1;
                  if (skip_remaining_next == '0) begin
                    res_valid             = 1'b1;
                    phase_next            = PH_ENTRY;
                    entry_byte_index_next = '0;
                  end
                end
                default: begin
                end
              endcase
              if (res_valid) begin
                res.result_kind      = KIND_ENTRY;
                res.stream_type      = entry_type_next;
                res.es_pid           = entry_pid_next;
                res.es_info_len      = entry_info_len_next;
                res.subtitle_present = entry_sub_flag_next;
                res.language_code    = entry_language_next;
                res.subtitle_entries = entry_sub_count_next;
              end
            end
            byte_position_next = pos_plus1[11:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      byte_position    <= '0;
      section_len      <= '0;
      skip_remaining   <= '0;
      entry_byte_index <= '0;
      desc_byte_index  <= '0;
      hdr_prog         <= '0;
      hdr_version      <= '0;
      hdr_pcr          <= '0;
      entry_type       <= '0;
      entry_pid        <= '0;
      entry_info_len   <= '0;
      entry_sub_flag   <= 1'b0;
      entry_language   <= '0;
      entry_sub_count  <= '0;
    end else begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      section_len      <= section_len_next;
      skip_remaining   <= skip_remaining_next;
      entry_byte_index <= entry_byte_index_next;
      desc_byte_index  <= desc_byte_index_next;
      hdr_prog         <= hdr_prog_next;
      hdr_version      <= hdr_version_next;
      hdr_pcr          <= hdr_pcr_next;
      entry_type       <= entry_type_next;
      entry_pid        <= entry_pid_next;
      entry_info_len   <= entry_info_len_next;
      entry_sub_flag   <= entry_sub_flag_next;
      entry_language   <= entry_language_next;
      entry_sub_count  <= entry_sub_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pmt_sec_out_stage.sv =====
// ----------------------------------------------------------------------------
// PMT section parser result register
// Holds one result until the consumer takes the request.
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_sec_out_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic                res_valid,
  input  wire pmt_sec_pkg::result_t res,
  output logic                     can_load,
  pmt_sec_out_if.source            out_ch
);
  import pmt_sec_pkg::*;

  logic    valid;
  result_t held;

  assign can_load = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (step) begin
      valid <= res_valid;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      held <= res;
    end
  end

  assign out_ch.valid            = valid;
  assign out_ch.result_kind      = held.result_kind;
  assign out_ch.program_number   = held.program_number;
  assign out_ch.version          = held.version;
  assign out_ch.pcr_pid          = held.pcr_pid;
  assign out_ch.stream_type      = held.stream_type;
  assign out_ch.es_pid           = held.es_pid;
  assign out_ch.es_info_len      = held.es_info_len;
  assign out_ch.subtitle_present = held.subtitle_present;
  assign out_ch.language_code    = held.language_code;
  assign out_ch.subtitle_entries = held.subtitle_entries;
  assign out_ch.section_done     = held.section_done;

endmodule

`default_nettype wire

// ===== rtl/pmt_section_parser_top.sv =====
// ----------------------------------------------------------------------------
// PMT section parser
// Parses a program map section one byte at a time into header, stream entry
// and section end results.
//
//   channel   dir  payload                                   handshake
//   in_ch     in   data_byte, section_start                  valid/ready
//   out_ch    out  result_kind .. section_done (11 fields)   valid/ready
//   cfg       in   cfg_data (subtitle tag)                   cfg_write
//
// One byte per cycle sustained while out_ch does not stall; each byte passes
// the input register, then its result is held in the result register.
// Synchronous active-high reset returns the parser to idle and the subtitle
// tag to 0x59.
// A stalled result register holds the input register, which then holds off
// the next request; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_section_parser_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [7:0] cfg_data,
  pmt_sec_in_if.sink      in_ch,
  pmt_sec_out_if.source   out_ch
);
  import pmt_sec_pkg::*;

  in_item_t item;
  result_t  res;
  logic     step;
  logic     can_load;
  logic     res_valid;

  pmt_sec_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .can_load (can_load),
    .item     (item),
    .step     (step)
  );

  pmt_sec_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  pmt_sec_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== test/pmt_result_checker.sv =====
// ----------------------------------------------------------------------------
// PMT section parser result checker
// Watches the byte and result channels and the subtitle tag port, runs its
// own byte-level parse of each accepted request, and compares every accepted
// result field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_result_checker
  import pmt_sec_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [7:0] cfg_data,
  pmt_sec_in_if      in_ch,
  pmt_sec_out_if     out_ch,
  output int         failures,
  output int         pending
);

  result_t     due_results[$];
  result_t     want;

  logic [7:0]  sub_tag;
  phase_t      ph;
  logic [11:0] pos;
  logic [11:0] sec_len;
  logic [11:0] skip_left;
  logic [2:0]  ent_idx;
  logic [2:0]  desc_idx;
  logic [15:0] prog;
  logic [4:0]  ver;
  logic [12:0] pcr;
  logic [7:0]  es_type;
  logic [12:0] es_pid_r;
  logic [11:0] es_len;
  logic        sub_flag;
  logic [23:0] lang;
  logic [4:0]  sub_cnt;

  task automatic clear_parser();
    sub_tag   = SUBTITLE_TAG_RST;
    ph        = PH_IDLE;
    pos       = '0;
    sec_len   = '0;
    skip_left = '0;
    ent_idx   = '0;
    desc_idx  = '0;
    prog      = '0;
    ver       = '0;
    pcr       = '0;
    es_type   = '0;
    es_pid_r  = '0;
    es_len    = '0;
    sub_flag  = 1'b0;
    lang      = '0;
    sub_cnt   = '0;
  endtask

  task automatic close_entry();
    result_t r;
    r = '0;
    r.result_kind      = KIND_ENTRY;
    r.stream_type      = es_type;
    r.es_pid           = es_pid_r;
    r.es_info_len      = es_len;
    r.subtitle_present = sub_flag;
    r.language_code    = lang;
    r.subtitle_entries = sub_cnt;
    due_results.push_back(r);
    ph      = PH_ENTRY;
    ent_idx = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic first);
    result_t r;
    int      k;
    r = '0;
    k = 0;
    if (first) begin
      ph        = PH_HDR;
      pos       = '0;
      sec_len   = '0;
      skip_left = '0;
    end
    if (ph == PH_HDR) begin
      case (pos)
        HDR_LEN_HI:   sec_len   = {b[3:0], 8'h00};
        HDR_LEN_LO:   sec_len   = sec_len | {4'h0, b};
        HDR_PROG_HI:  prog      = {b, 8'h00};
        HDR_PROG_LO:  prog      = prog | {8'h00, b};
        HDR_VERSION:  ver       = b[5:1];
        HDR_PCR_HI:   pcr       = {b[4:0], 8'h00};
        HDR_PCR_LO:   pcr       = pcr | {5'h00, b};
        HDR_PINFO_HI: skip_left = {b[3:0], 8'h00};
        HDR_LAST:     skip_left = skip_left | {4'h0, b};
        default: ;
      endcase
      if (pos < HDR_LAST) begin
        pos = pos + 12'd1;
      end else begin
        r.result_kind    = KIND_HEADER;
        r.program_number = prog;
        r.version        = ver;
        r.pcr_pid        = pcr;
        if (sec_len <= SHORT_SECTION_LEN) begin
          r.section_done = 1'b1;
          ph  = PH_IDLE;
          pos = '0;
        end else begin
          pos     = BODY_START_POS;
          ent_idx = '0;
          ph      = (skip_left != '0) ? PH_PINFO : PH_ENTRY;
        end
        due_results.push_back(r);
      end
    end else if (ph != PH_IDLE) begin
      k = int'(pos);
      if (k + 1 == int'(sec_len)) begin
        r.result_kind  = KIND_END;
        r.section_done = 1'b1;
        due_results.push_back(r);
        ph  = PH_IDLE;
        pos = '0;
      end else begin
        // the last four bytes are CRC: anything unfinished is dropped
        if (k + 4 >= int'(sec_len)) begin
          ph = PH_TAIL;
        end else begin
          case (ph)
            PH_PINFO: begin
              skip_left = skip_left - 12'd1;
              if (skip_left == '0) begin
                ph      = PH_ENTRY;
                ent_idx = '0;
              end
            end
            PH_ENTRY: begin
              case (ent_idx)
                3'd0:    es_type  = b;
                3'd1:    es_pid_r = {b[4:0], 8'h00};
                3'd2:    es_pid_r = es_pid_r | {5'h00, b};
                3'd3:    es_len   = {b[3:0], 8'h00};
                default: es_len   = es_len | {4'h0, b};
              endcase
              if (ent_idx < ENTRY_LAST_BYTE) begin
                ent_idx = ent_idx + 3'd1;
              end else begin
                sub_flag = 1'b0;
                lang     = '0;
                sub_cnt  = '0;
                desc_idx = '0;
                if (es_len == '0) begin
                  close_entry();
                end else begin
                  skip_left = es_len;
                  ph        = PH_DESC;
                end
              end
            end
            PH_DESC: begin
              if (desc_idx == '0) begin
                sub_flag = (b == sub_tag);
              end else if (sub_flag) begin
                if (desc_idx == DESC_COUNT_BYTE) sub_cnt = b[7:3];
                else if (desc_idx <= DESC_LANG_LAST) lang = {lang[15:0], b};
              end
              if (desc_idx < DESC_INDEX_MAX) desc_idx = desc_idx + 3'd1;
              skip_left = skip_left - 12'd1;
              if (skip_left == '0) close_entry();
            end
            default: ;
          endcase
        end
        pos = pos + 12'd1;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] exp_val,
                             input logic [23:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
               act_val);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      due_results.delete();
      failures = 0;
    end else begin
      if (cfg_write) sub_tag = cfg_data;
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d", $time,
                   out_ch.result_kind);
          failures++;
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", 24'(want.result_kind), 24'(out_ch.result_kind));
          check_field("program_number", 24'(want.program_number),
                      24'(out_ch.program_number));
          check_field("version", 24'(want.version), 24'(out_ch.version));
          check_field("pcr_pid", 24'(want.pcr_pid), 24'(out_ch.pcr_pid));
          check_field("stream_type", 24'(want.stream_type), 24'(out_ch.stream_type));
          check_field("es_pid", 24'(want.es_pid), 24'(out_ch.es_pid));
          check_field("es_info_len", 24'(want.es_info_len), 24'(out_ch.es_info_len));
          check_field("subtitle_present", 24'(want.subtitle_present),
                      24'(out_ch.subtitle_present));
          check_field("language_code", want.language_code, out_ch.language_code);
          check_field("subtitle_entries", 24'(want.subtitle_entries),
                      24'(out_ch.subtitle_entries));
          check_field("section_done", 24'(want.section_done),
                      24'(out_ch.section_done));
        end
      end
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.data_byte, in_ch.section_start);
    end
    pending = due_results.size();
  end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// PMT section parser testbench
// Feeds directed and random program map sections, broken and cut sections
// and stray bytes through the parser under random idling on both channels,
// changes the subtitle tag between phases, and reports the checker verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import pmt_sec_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 150;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [7:0] cfg_data;
  int         failures;
  int         pending;

  in_item_t   feed[$];
  bit         calm;
  bit         hold_req;
  int         bytes_queued;
  logic [7:0] cur_tag;

  pmt_sec_in_if  in_ch ();
  pmt_sec_out_if out_ch ();

  pmt_section_parser_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  pmt_result_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("testbench: FAIL");
    $finish;
  end

  // byte source: present queued requests, with random gaps between them
  initial begin : byte_source
    int gap;
    gap = 0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.section_start = 1'b0;
    forever begin
      @(negedge clk);
      if (gap > 0) begin
        gap--;
        in_ch.valid <= 1'b0;
      end else if (feed.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 19) - 1;
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= feed[0].data_byte;
        in_ch.section_start <= feed[0].section_start;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        void'(feed.pop_front());
      end
    end
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (hold > 0) begin
        hold--;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        hold = $urandom_range(1, 19) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic first);
    in_item_t it;
    it.data_byte     = b;
    it.section_start = first;
    feed.push_back(it);
  endtask

  // Build one section. len_adj moves the length field off the true size,
  // cut_after >= 0 stops sending early, force_len >= 0 overrides the length.
  task automatic add_section(input int streams, input int pinfo, input int max_info,
                             input int len_adj, input int cut_after,
                             input int force_len, input int sub_pct);
    logic [7:0]  body[$];
    logic [7:0]  hdr[12];
    logic [31:0] rnd;
    logic [11:0] len12;
    logic [11:0] pinfo12;
    logic [11:0] info12;
    int          len, total, i, s, d;
    for (i = 0; i < pinfo; i++) body.push_back(8'($urandom));
    for (s = 0; s < streams; s++) begin
      info12 = 12'($urandom_range(0, max_info));
      rnd = $urandom;
      body.push_back(rnd[7:0]);
      body.push_back(rnd[15:8]);
      body.push_back(rnd[23:16]);
      body.push_back({rnd[31:28], info12[11:8]});
      body.push_back(info12[7:0]);
      for (d = 0; d < int'(info12); d++) begin
        if (d == 0 && $urandom_range(0, 99) < sub_pct) body.push_back(cur_tag);
        else body.push_back(8'($urandom));
      end
    end
    len = (force_len >= 0) ? force_len : 13 + body.size() + len_adj;
    if (len < 0) len = 0;
    if (len > 4095) len = 4095;
    len12   = 12'(len);
    pinfo12 = 12'(pinfo);
    rnd     = $urandom;
    hdr[0]  = ($urandom_range(0, 3) == 0) ? rnd[7:0] : 8'h02;
    hdr[1]  = {rnd[11:8], len12[11:8]};
    hdr[2]  = len12[7:0];
    for (i = 3; i < 10; i++) hdr[i] = 8'($urandom);
    hdr[10] = {rnd[15:12], pinfo12[11:8]};
    hdr[11] = pinfo12[7:0];
    total = 12 + ((len > 9) ? len - 9 : 0);
    // CRC and any extra bytes are random
    while (body.size() < total - 12) body.push_back(8'($urandom));
    for (i = 0; i < total; i++) begin
      if (cut_after >= 0 && i >= cut_after) break;
      push_byte((i < 12) ? hdr[i] : body[i - 12], i == 0);
      bytes_queued++;
    end
  endtask

  task automatic random_phase(input int budget);
    int start_count, pick, pinfo;
    start_count = bytes_queued;
    while (bytes_queued - start_count < budget) begin
      pick  = $urandom_range(0, 19);
      pinfo = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (pick < 13)
        add_section($urandom_range(0, 5), pinfo, 12, 0, -1, -1, 50);
      else if (pick < 15)
        add_section($urandom_range(1, 4), pinfo, 10, -$urandom_range(1, 10), -1, -1, 50);
      else if (pick < 16)
        add_section($urandom_range(1, 4), pinfo, 10, 0, $urandom_range(1, 30), -1, 50);
      else if (pick < 17)
        add_section(0, 0, 0, 0, -1, $urandom_range(0, 12), 50);
      else if (pick < 18)
        add_section($urandom_range(0, 3), pinfo, 8, $urandom_range(1, 6), -1, -1, 50);
      else
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom), $urandom_range(0, 9) == 0);
    end
  endtask

  // wait for every request to be taken and every result to arrive
  task automatic drain();
    do @(negedge clk); while (feed.size() != 0 || pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_tag(input logic [7:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_tag = v;
  endtask

  initial begin
    int i;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_data     = '0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    bytes_queued = 0;
    cur_tag      = SUBTITLE_TAG_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // stray bytes while idle
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    // short section with all-ones fields
    push_byte(8'hFF, 1'b1);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h09, 1'b0);
    for (i = 0; i < 9; i++) push_byte(8'hFF, 1'b0);
    // all-zero short section
    push_byte(8'h00, 1'b1);
    for (i = 0; i < 11; i++) push_byte(8'h00, 1'b0);
    add_section(3, 2, 12, 0, -1, -1, 100);
    add_section(2, 0, 6, 0, 20, -1, 50);
    add_section(3, 1, 10, -6, -1, -1, 50);
    add_section(2, 0, 3, 0, -1, -1, 100);
    add_section(2, 0, 12, 0, -1, -1, 0);
    add_section(0, 0, 0, 0, -1, 11, 50);

    write_tag(8'h00);
    random_phase(90);

    write_tag(8'hFF);
    // dense entries while the sink holds off
    hold_req = 1'b1;
    add_section(30, 0, 0, 0, -1, -1, 0);
    random_phase(60);

    write_tag(8'($urandom));
    add_section(1, 260, 300, 0, -1, -1, 50);
    random_phase(40);

    write_tag(SUBTITLE_TAG_RST);
    random_phase(50);
    drain();
    calm = 1'b1;
    random_phase(50);

    drain();
    if (failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/pmt_sec_pkg.sv
rtl/pmt_sec_if.sv
rtl/pmt_sec_in_stage.sv
rtl/pmt_sec_parse.sv
rtl/pmt_sec_out_stage.sv
rtl/pmt_section_parser_top.sv
test/pmt_result_checker.sv
test/testbench.sv
